// ===== design/diff_drive_wheel_odometry_defines.svh =====
// Shared assertion macros for the odometry block.
`ifndef DIFF_DRIVE_WHEEL_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_WHEEL_ODOMETRY_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, skipped while reset is asserted
`define DDWO_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset
`define DDWO_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDWO_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define DDWO_ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

// ===== design/ddwo_pkg.sv =====
package ddwo_pkg;

    // CORDIC setup
    localparam int TRIG_ITERS = 16;
    localparam int TAB_LEN    = 24;
    localparam int ITER_W     = $clog2(TAB_LEN);
    localparam int TRIG_W     = 34;
    localparam logic signed [TRIG_W-1:0] CORDIC_K = 34'sd652032874;

    // Serial multiplier widths
    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_N_W = 6;

    // Position clamp, 2^-32 m
    localparam logic signed [49:0] POS_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] POS_MIN = -50'sd140737488355328;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd2;
    localparam logic [23:0] DIST_RST = 24'd217417;
    localparam logic [23:0] YAW_RST  = 24'd173015;
    localparam logic [9:0]  RATE_RST = 10'd20;

    typedef struct packed {
        logic [11:0] left_raw;
        logic [11:0] right_raw;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [31:0] lin_vel;
        logic signed [31:0] ang_vel;
    } t_out;

    typedef struct packed {
        logic               start;
        logic [MUL_N_W-1:0] nbits;
    } t_mul_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_MUL_Y,
        ST_MUL_L,
        ST_MUL_A,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_P,
        ST_OUT
    } t_state;

    // Arctangent of 2^-i in 2^-32 turn
    function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ddwo_mul.sv =====
// Bit-serial unsigned multiplier, MSB of B first, one bit per cycle
module ddwo_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ddwo_pkg::t_mul_req                i_req,
    input  logic [ddwo_pkg::MUL_A_W-1:0]      i_a,
    input  logic [ddwo_pkg::MUL_B_W-1:0]      i_b,
    output logic                              o_done,
    output logic [ddwo_pkg::MUL_P_W-1:0]      o_prod
);

    logic [ddwo_pkg::MUL_A_W-1:0] r_a;
    logic [ddwo_pkg::MUL_B_W-1:0] r_b;
    logic [ddwo_pkg::MUL_P_W-1:0] r_acc;
    logic [ddwo_pkg::MUL_P_W-1:0] n_acc;
    logic [ddwo_pkg::MUL_N_W-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;

    // shift-and-add step
    assign n_acc = {r_acc[ddwo_pkg::MUL_P_W-2:0], 1'b0}
                 + (r_b[ddwo_pkg::MUL_B_W-1]
                    ? {{ddwo_pkg::MUL_B_W{1'b0}}, r_a}
                    : {ddwo_pkg::MUL_P_W{1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
                r_a    <= i_a;
                // left-align the active bits of B
                r_b    <= i_b << (ddwo_pkg::MUL_N_W'(ddwo_pkg::MUL_B_W) - i_req.nbits);
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= {r_b[ddwo_pkg::MUL_B_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ddwo_pkg::MUL_N_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== design/ddwo_cordic.sv =====
// Iterative rotation CORDIC, one micro-rotation per cycle
module ddwo_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [31:0]                       i_ang,
    output logic                              o_done,
    output logic signed [ddwo_pkg::TRIG_W-1:0] o_cos,
    output logic signed [ddwo_pkg::TRIG_W-1:0] o_sin
);

    logic signed [ddwo_pkg::TRIG_W-1:0] r_x;
    logic signed [ddwo_pkg::TRIG_W-1:0] r_y;
    logic signed [ddwo_pkg::TRIG_W-1:0] r_z;
    logic [1:0]                         r_q;
    logic [ddwo_pkg::ITER_W-1:0]        r_i;
    logic                               r_busy;
    logic                               r_done;
    logic [31:0]                        ang_bias;
    logic [1:0]                         q;
    logic [31:0]                        rem;
    logic signed [ddwo_pkg::TRIG_W-1:0] dx;
    logic signed [ddwo_pkg::TRIG_W-1:0] dy;
    logic signed [ddwo_pkg::TRIG_W-1:0] at;

    // reduce to +-1/8 turn around the nearest quadrant
    assign ang_bias = i_ang + 32'h2000_0000;
    assign q        = ang_bias[31:30];
    assign rem      = i_ang - {q, 30'd0};

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = $signed({2'b00, ddwo_pkg::atan_entry(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_q    <= q;
                r_x    <= ddwo_pkg::CORDIC_K;
                r_y    <= '0;
                r_z    <= $signed({{2{rem[31]}}, rem});
            end else if (r_busy) begin
                if (!r_z[ddwo_pkg::TRIG_W-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == ddwo_pkg::ITER_W'(ddwo_pkg::TRIG_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // rotate back by the quadrant
    always_comb begin
        case (r_q)
            2'd0: begin
                o_cos = r_x;
                o_sin = r_y;
            end
            2'd1: begin
                o_cos = -r_y;
                o_sin = r_x;
            end
            2'd2: begin
                o_cos = -r_x;
                o_sin = -r_y;
            end
            default: begin
                o_cos = r_y;
                o_sin = -r_x;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

// ===== design/diff_drive_wheel_odometry.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | i_in_valid / o_in_stall | i_in_data  (left_raw, right_raw)
// out     | output    | o_out_valid / i_out_stall | o_out_data (pose, velocities)
// cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// Each item runs six bit-serial multiplies (13, 13, 10, 10, 32 and 32
// bits, each with a launch and a completion step), a 16-iteration CORDIC
// and an output step, run back to back, with all multiplies on one shared
// multiplier. One item is in work at a time; the next is taken in idle,
// once the result has been loaded into the output register.
// Reset is synchronous, active low, clears pose and last counts and restores
// the config defaults.
// A stalled output holds its transfer; the next item may still be accepted.
`include "diff_drive_wheel_odometry_defines.svh"
module diff_drive_wheel_odometry (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  ddwo_pkg::t_in                        i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output ddwo_pkg::t_out                       o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [ddwo_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [23:0]                          i_cfg_data
);

    ddwo_pkg::t_state r_state;
    ddwo_pkg::t_state n_state;
    logic             r_launched;
    logic             n_launched;

    logic [23:0] r_dist;
    logic [23:0] r_yawpc;
    logic [9:0]  r_rate;

    logic [11:0]        r_last_l;
    logic [11:0]        r_last_r;
    logic [31:0]        r_yaw;
    logic signed [47:0] r_x;
    logic signed [47:0] r_y;

    logic        r_sumc_neg;
    logic [12:0] r_sumc_mag;
    logic        r_difc_neg;
    logic [12:0] r_difc_mag;
    logic        r_sum_neg;
    logic [36:0] r_sum_mag;
    logic        r_dy_neg;
    logic [36:0] r_dy_mag;
    logic [31:0] r_lin;
    logic [31:0] r_ang;
    logic        r_c_neg;
    logic [31:0] r_c_mag;
    logic        r_s_neg;
    logic [31:0] r_s_mag;

    ddwo_pkg::t_out r_out;
    logic           r_out_valid;

    logic                          in_acc;
    logic                          out_free;
    logic                          in_mul_step;
    ddwo_pkg::t_mul_req            mul_req;
    logic [ddwo_pkg::MUL_A_W-1:0]  mul_a;
    logic [ddwo_pkg::MUL_B_W-1:0]  mul_b;
    logic                          mul_done;
    logic [ddwo_pkg::MUL_P_W-1:0]  mul_prod;
    logic                          cor_start;
    logic                          cor_done;
    logic signed [ddwo_pkg::TRIG_W-1:0] cor_cos;
    logic signed [ddwo_pkg::TRIG_W-1:0] cor_sin;

    logic signed [11:0] dl;
    logic signed [11:0] dr;
    logic signed [12:0] sumc;
    logic signed [12:0] difc;
    logic [47:0]        vel_v;
    logic [47:0]        dy_v;
    logic [37:0]        step_mag;
    logic               step_neg;
    logic signed [49:0] step_v;
    logic signed [47:0] pos_old;
    logic signed [49:0] pos_sum;
    logic signed [47:0] pos_new;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // steps that run on the shared multiplier
    assign in_mul_step = r_state inside {ddwo_pkg::ST_MUL_S, ddwo_pkg::ST_MUL_Y,
                                         ddwo_pkg::ST_MUL_L, ddwo_pkg::ST_MUL_A,
                                         ddwo_pkg::ST_MUL_X, ddwo_pkg::ST_MUL_P};

    // wheel deltas: modular 12-bit difference read as signed
    assign dl   = $signed(i_in_data.left_raw - r_last_l);
    assign dr   = $signed(i_in_data.right_raw - r_last_r);
    assign sumc = {dl[11], dl} + {dr[11], dr};
    assign difc = {dr[11], dr} - {dl[11], dl};

    // signed value of the current product for velocity and yaw paths
    assign vel_v = (r_state == ddwo_pkg::ST_MUL_L ? r_sum_neg : r_dy_neg)
                   ? -{1'b0, mul_prod[46:0]} : {1'b0, mul_prod[46:0]};
    assign dy_v  = r_difc_neg ? -{11'd0, mul_prod[36:0]} : {11'd0, mul_prod[36:0]};

    // position step, truncated toward zero, then saturating add
    assign step_mag = mul_prod[68:31];
    assign step_neg = r_sum_neg != ((r_state == ddwo_pkg::ST_MUL_X) ? r_c_neg : r_s_neg);
    assign step_v   = step_neg ? -$signed({12'd0, step_mag}) : $signed({12'd0, step_mag});
    assign pos_old  = (r_state == ddwo_pkg::ST_MUL_X) ? r_x : r_y;
    assign pos_sum  = $signed({{2{pos_old[47]}}, pos_old}) + step_v;

    always_comb begin
        if (pos_sum > ddwo_pkg::POS_MAX) begin
            pos_new = ddwo_pkg::POS_MAX[47:0];
        end else if (pos_sum < ddwo_pkg::POS_MIN) begin
            pos_new = ddwo_pkg::POS_MIN[47:0];
        end else begin
            pos_new = pos_sum[47:0];
        end
    end

    // sequencer: next state and unit launches
    always_comb begin
        n_state       = r_state;
        n_launched    = r_launched;
        mul_req.start = 1'b0;
        mul_req.nbits = '0;
        mul_a         = '0;
        mul_b         = '0;
        cor_start     = 1'b0;
        o_in_stall    = 1'b1;
        case (r_state)
            ddwo_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = ddwo_pkg::ST_MUL_S;
                end
            end
            ddwo_pkg::ST_MUL_S: begin
                mul_req.nbits = ddwo_pkg::MUL_N_W'(13);
                mul_a         = {13'd0, r_dist};
                mul_b         = {19'd0, r_sumc_mag};
            end
            ddwo_pkg::ST_MUL_Y: begin
                mul_req.nbits = ddwo_pkg::MUL_N_W'(13);
                mul_a         = {13'd0, r_yawpc};
                mul_b         = {19'd0, r_difc_mag};
            end
            ddwo_pkg::ST_MUL_L: begin
                mul_req.nbits = ddwo_pkg::MUL_N_W'(10);
                mul_a         = r_sum_mag;
                mul_b         = {22'd0, r_rate};
            end
            ddwo_pkg::ST_MUL_A: begin
                mul_req.nbits = ddwo_pkg::MUL_N_W'(10);
                mul_a         = r_dy_mag;
                mul_b         = {22'd0, r_rate};
            end
            ddwo_pkg::ST_CORDIC: begin
                if (!r_launched) begin
                    cor_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (cor_done) begin
                    n_launched = 1'b0;
                    n_state    = ddwo_pkg::ST_MUL_X;
                end
            end
            ddwo_pkg::ST_MUL_X: begin
                mul_req.nbits = ddwo_pkg::MUL_N_W'(32);
                mul_a         = r_sum_mag;
                mul_b         = r_c_mag;
            end
            ddwo_pkg::ST_MUL_P: begin
                mul_req.nbits = ddwo_pkg::MUL_N_W'(32);
                mul_a         = r_sum_mag;
                mul_b         = r_s_mag;
            end
            ddwo_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = ddwo_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ddwo_pkg::ST_IDLE;
            end
        endcase

        // common launch and completion for the multiply steps
        if (in_mul_step) begin
            if (!r_launched) begin
                mul_req.start = 1'b1;
                n_launched    = 1'b1;
            end else if (mul_done) begin
                n_launched = 1'b0;
                case (r_state)
                    ddwo_pkg::ST_MUL_S: n_state = ddwo_pkg::ST_MUL_Y;
                    ddwo_pkg::ST_MUL_Y: n_state = ddwo_pkg::ST_MUL_L;
                    ddwo_pkg::ST_MUL_L: n_state = ddwo_pkg::ST_MUL_A;
                    ddwo_pkg::ST_MUL_A: n_state = ddwo_pkg::ST_CORDIC;
                    ddwo_pkg::ST_MUL_X: n_state = ddwo_pkg::ST_MUL_P;
                    default:            n_state = ddwo_pkg::ST_OUT;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ddwo_pkg::ST_IDLE;
            r_launched  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dist      <= ddwo_pkg::DIST_RST;
            r_yawpc     <= ddwo_pkg::YAW_RST;
            r_rate      <= ddwo_pkg::RATE_RST;
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_yaw       <= '0;
            r_x         <= '0;
            r_y         <= '0;
        end else begin
            r_state    <= n_state;
            r_launched <= n_launched;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ddwo_pkg::CFG_DIST: r_dist  <= i_cfg_data;
                    ddwo_pkg::CFG_YAW:  r_yawpc <= i_cfg_data;
                    ddwo_pkg::CFG_RATE: r_rate  <= i_cfg_data[9:0];
                    default: ;
                endcase
            end

            // input transfer: unwrap and keep sign/magnitude of the count sum and difference
            if (in_acc) begin
                r_last_l   <= i_in_data.left_raw;
                r_last_r   <= i_in_data.right_raw;
                r_sumc_neg <= sumc[12];
                r_sumc_mag <= sumc[12] ? 13'(-sumc) : 13'(sumc);
                r_difc_neg <= difc[12];
                r_difc_mag <= difc[12] ? 13'(-difc) : 13'(difc);
            end

            // capture each finished multiply
            if (r_launched && mul_done) begin
                case (r_state)
                    ddwo_pkg::ST_MUL_S: begin
                        r_sum_neg <= r_sumc_neg;
                        r_sum_mag <= mul_prod[36:0];
                    end
                    ddwo_pkg::ST_MUL_Y: begin
                        r_dy_neg <= r_difc_neg;
                        r_dy_mag <= mul_prod[36:0];
                        r_yaw    <= r_yaw + dy_v[31:0];
                    end
                    // both velocities stay within 31 bits, so no clamp
                    ddwo_pkg::ST_MUL_L: r_lin <= {vel_v[47], vel_v[47:17]};
                    ddwo_pkg::ST_MUL_A: r_ang <= vel_v[47:16];
                    ddwo_pkg::ST_MUL_X: r_x <= pos_new;
                    ddwo_pkg::ST_MUL_P: r_y <= pos_new;
                    default: ;
                endcase
            end

            // cos/sin as sign and magnitude for the serial multiplier
            if (r_state == ddwo_pkg::ST_CORDIC && cor_done) begin
                r_c_neg <= cor_cos[ddwo_pkg::TRIG_W-1];
                r_c_mag <= cor_cos[ddwo_pkg::TRIG_W-1] ? 32'(-cor_cos) : 32'(cor_cos);
                r_s_neg <= cor_sin[ddwo_pkg::TRIG_W-1];
                r_s_mag <= cor_sin[ddwo_pkg::TRIG_W-1] ? 32'(-cor_sin) : 32'(cor_sin);
            end

            // output register
            if (r_state == ddwo_pkg::ST_OUT && out_free) begin
                r_out_valid     <= 1'b1;
                r_out.pos_x     <= r_x[47:16];
                r_out.pos_y     <= r_y[47:16];
                r_out.heading   <= r_yaw[31:16];
                r_out.lin_vel   <= r_lin;
                r_out.ang_vel   <= r_ang;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    ddwo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ddwo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_ang   (r_yaw),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    // multiplier completes only while a multiply step waits for it
    `DDWO_ASSERT_RST(a_mul_done_state, i_clk, i_rst_n, mul_done |-> (r_launched && in_mul_step), "multiplier finished outside a multiply step")
    // CORDIC completes only in its own step
    `DDWO_ASSERT_RST(a_cor_done_state, i_clk, i_rst_n, cor_done |-> (r_state == ddwo_pkg::ST_CORDIC && r_launched), "CORDIC finished outside its step")
    // a new result appears only from the output step
    `DDWO_ASSERT_RST(a_out_from_seq, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == ddwo_pkg::ST_OUT), "result raised without the output step")
    // no item is taken while one is in work
    `DDWO_ASSERT_ALL(a_in_only_idle, i_clk, (i_rst_n && !o_in_stall) |-> (r_state == ddwo_pkg::ST_IDLE), "input open while busy")

endmodule

// ===== verif/diff_drive_wheel_odometry_chk.sv =====
module diff_drive_wheel_odometry_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  ddwo_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  ddwo_pkg::t_out i_out_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [23:0]    i_cfg_data,
    output int             o_fail_cnt,
    output int             o_pending,
    output int             o_pose_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint POS_MAX = 64'sd140737488355327;
    localparam longint POS_MIN = -64'sd140737488355328;

    logic [23:0]    dist_gain;
    logic [23:0]    turn_gain;
    logic [9:0]     tick_rate;
    logic [11:0]    prev_left;
    logic [11:0]    prev_right;
    logic [31:0]    yaw;
    longint         x_pos;
    longint         y_pos;
    ddwo_pkg::t_out pose_q[$];

    function automatic longint wrap_delta(logic [11:0] now_v, logic [11:0] prev_v);
        logic [11:0] d;
        d = now_v - prev_v;
        return longint'($signed(d));
    endfunction

    // CORDIC rotation with quadrant folding; returns Q30 cos/sin
    task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
        logic [1:0]  quad;
        logic [31:0] rem;
        longint      z, xv, yv, dx, dy;
        quad = 2'((ang + 32'h2000_0000) >> 30);
        rem  = ang - {quad, 30'd0};
        z    = longint'($signed(rem));
        xv   = ddwo_pkg::CORDIC_K;
        yv   = 0;
        for (int i = 0; i < ddwo_pkg::TRIG_ITERS && i < ddwo_pkg::TAB_LEN; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (z >= 0) begin
                xv -= dx; yv += dy;
                z -= longint'(ddwo_pkg::atan_entry(ddwo_pkg::ITER_W'(i)));
            end else begin
                xv += dx; yv -= dy;
                z += longint'(ddwo_pkg::atan_entry(ddwo_pkg::ITER_W'(i)));
            end
        end
        case (quad)
            2'd0: begin c = xv;  s = yv;  end
            2'd1: begin c = -yv; s = xv;  end
            2'd2: begin c = -xv; s = -yv; end
            default: begin c = yv; s = -xv; end
        endcase
    endtask

    // a*b/2^31, truncated toward zero
    function automatic longint scale_q31(longint a, longint b);
        logic [127:0] p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        p   = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        p   = p >> 31;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    task automatic predict_pose(input ddwo_pkg::t_in it);
        longint         dl, dr, sum_d, dyaw, c, s;
        ddwo_pkg::t_out r;
        dl = wrap_delta(it.left_raw, prev_left);
        dr = wrap_delta(it.right_raw, prev_right);
        prev_left  = it.left_raw;
        prev_right = it.right_raw;
        sum_d = (dl + dr) * longint'(dist_gain);
        dyaw  = (dr - dl) * longint'(turn_gain);
        yaw   = yaw + dyaw[31:0];
        rotate(yaw, c, s);
        x_pos = clamp(x_pos + scale_q31(sum_d, c), POS_MIN, POS_MAX);
        y_pos = clamp(y_pos + scale_q31(sum_d, s), POS_MIN, POS_MAX);
        r.pos_x   = 32'(x_pos >>> 16);
        r.pos_y   = 32'(y_pos >>> 16);
        r.heading = yaw[31:16];
        r.lin_vel = 32'(clamp((sum_d * longint'(tick_rate)) >>> 17,
                              -64'sd2147483648, 64'sd2147483647));
        r.ang_vel = 32'(clamp((dyaw * longint'(tick_rate)) >>> 16,
                              -64'sd2147483648, 64'sd2147483647));
        pose_q.push_back(r);
    endtask

    task automatic cmp(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        ddwo_pkg::t_out e;
        if (!i_rst_n) begin
            dist_gain  <= ddwo_pkg::DIST_RST;
            turn_gain  <= ddwo_pkg::YAW_RST;
            tick_rate  <= ddwo_pkg::RATE_RST;
            prev_left  = '0;
            prev_right = '0;
            yaw        = '0;
            x_pos      = 0;
            y_pos      = 0;
            pose_q.delete();
            o_fail_cnt = 0;
            o_pose_cnt = 0;
            o_pending  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ddwo_pkg::CFG_DIST: dist_gain <= i_cfg_data;
                    ddwo_pkg::CFG_YAW:  turn_gain <= i_cfg_data;
                    ddwo_pkg::CFG_RATE: tick_rate <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            // compare before predicting so an item never matches itself
            if (i_out_valid && !i_out_stall) begin
                o_pose_cnt++;
                if (pose_q.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    o_fail_cnt++;
                end else begin
                    e = pose_q.pop_front();
                    cmp("pos_x", e.pos_x, i_out_data.pos_x);
                    cmp("pos_y", e.pos_y, i_out_data.pos_y);
                    cmp("heading", e.heading, i_out_data.heading);
                    cmp("lin_vel", e.lin_vel, i_out_data.lin_vel);
                    cmp("ang_vel", e.ang_vel, i_out_data.ang_vel);
                end
            end
            if (i_in_valid && !i_in_stall) predict_pose(i_in_data);
            o_pending = pose_q.size();
        end
    end
endmodule

// ===== verif/diff_drive_wheel_odometry_tb.sv =====
module diff_drive_wheel_odometry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    ddwo_pkg::t_in  in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    ddwo_pkg::t_out out_data;
    logic           cfg_we = 1'b0;
    logic [1:0]     cfg_idx = '0;
    logic [23:0]    cfg_data = '0;
    int             fail_cnt, pending, pose_cnt;
    int             cycle_cnt = 0;
    logic [11:0]    lcur = '0, rcur = '0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    diff_drive_wheel_odometry u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    diff_drive_wheel_odometry_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_pose_cnt(pose_cnt)
    );

    // receiver stall pattern: quiet stretches, then random stalling
    always @(posedge clk) begin
        int ph;
        ph = (cycle_cnt / 3000) % 3;
        if (ph == 0) out_stall <= 1'b0;
        else if (ph == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 9) < 7);
    end

    // timeout watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic put_cfg(logic [1:0] idx, logic [23:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // one transfer; valid stays high when the next item follows at once
    task automatic send(logic [11:0] l, logic [11:0] r, bit keep);
        in_valid <= 1'b1;
        in_data  <= '{left_raw: l, right_raw: r};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        lcur = l;
        rcur = r;
        if (!keep) in_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // well-formed motion with moderate deltas, plus occasional wild jumps
    task automatic random_phase(int n);
        int burst, dl, dr;
        for (int i = 0; i < n; i++) begin
            if (burst <= 0) begin
                burst = $urandom_range(1, 12);
                repeat ($urandom_range(0, 40)) @(posedge clk);
            end
            burst--;
            if ($urandom_range(0, 9) == 0) begin
                dl = $urandom_range(0, 4095);
                dr = $urandom_range(0, 4095);
            end else begin
                dl = $urandom_range(0, 400) - 200;
                dr = dl + $urandom_range(0, 120) - 60;
            end
            send(12'(lcur + dl), 12'(rcur + dr), burst > 0 && i < n - 1);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, half turns, zero motion
        send(12'd0, 12'd0, 0);
        send(12'd2048, 12'd2048, 0);
        send(12'd0, 12'd2048, 0);
        send(12'd2047, 12'd4095, 1);
        send(12'd4095, 12'd2047, 1);
        send(12'd4095, 12'd4095, 0);
        send(12'd1, 12'd0, 0);
        send(12'h555, 12'hAAA, 1);
        send(12'hAAA, 12'h555, 0);
        drain();

        // maximum gains and rate: largest velocities, large pose steps
        put_cfg(ddwo_pkg::CFG_DIST, 24'hFFFFFF);
        put_cfg(ddwo_pkg::CFG_YAW, 24'hFFFFFF);
        put_cfg(ddwo_pkg::CFG_RATE, 24'hFFFFFF);
        for (int i = 0; i < 8; i++) send(12'(lcur + 2047), 12'(rcur + 2047), 1);
        send(12'(lcur + 2048), 12'(rcur + 2047), 0);
        drain();

        // zero gains and rate, plus a write to the unused index
        put_cfg(ddwo_pkg::CFG_DIST, 24'd0);
        put_cfg(ddwo_pkg::CFG_YAW, 24'd0);
        put_cfg(ddwo_pkg::CFG_RATE, 24'd0);
        put_cfg(2'd3, 24'h123456);
        send(12'd100, 12'd3000, 0);
        send(12'd3000, 12'd100, 0);
        drain();

        // reset values, then random mid settings
        put_cfg(ddwo_pkg::CFG_DIST, ddwo_pkg::DIST_RST);
        put_cfg(ddwo_pkg::CFG_YAW, ddwo_pkg::YAW_RST);
        put_cfg(ddwo_pkg::CFG_RATE, 24'(ddwo_pkg::RATE_RST));
        random_phase(400);
        drain();
        for (int p = 0; p < 3; p++) begin
            put_cfg(ddwo_pkg::CFG_DIST, 24'($urandom));
            put_cfg(ddwo_pkg::CFG_YAW, 24'($urandom));
            put_cfg(ddwo_pkg::CFG_RATE, 24'($urandom_range(1, 1023)));
            random_phase(300);
            drain();
        end

        // push the position toward its clamp with max distance gain in a straight line
        put_cfg(ddwo_pkg::CFG_DIST, 24'hFFFFFF);
        put_cfg(ddwo_pkg::CFG_YAW, 24'd0);
        put_cfg(ddwo_pkg::CFG_RATE, 24'd1000);
        random_phase(300);
        drain();

        $display("covered %0d results over directed extremes and %0d settings",
                 pose_cnt, 7);
        if (fail_cnt == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/ddwo_pkg.sv
design/ddwo_mul.sv
design/ddwo_cordic.sv
design/diff_drive_wheel_odometry.sv
verif/diff_drive_wheel_odometry_chk.sv
verif/diff_drive_wheel_odometry_tb.sv
